>>> sv/skh_pkg.sv
// shared types and constants for the serial key handshake block
`default_nettype none

package skh_pkg;

    // bits shifted out per attempt, msb first
    localparam int KEY_WIDTH = 16;
    localparam int BIT_POS_W = 5;
    localparam logic [BIT_POS_W-1:0] KEY_MSB_POS = BIT_POS_W'(KEY_WIDTH - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_VALUE     = 3'd0,
        CFG_CLOCK_LOW     = 3'd1,
        CFG_CLOCK_HIGH    = 3'd2,
        CFG_PAD_HIGH      = 3'd3,
        CFG_PAD_LOW       = 3'd4,
        CFG_ACK_LOW       = 3'd5,
        CFG_ACK_TIMEOUT   = 3'd6,
        CFG_RETRY_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_CLK_LOW  = 6'b000010,
        PH_CLK_HIGH = 6'b000100,
        PH_PAD_HIGH = 6'b001000,
        PH_PAD_LOW  = 6'b010000,
        PH_LISTEN   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic data_line_level;
        logic clock_line_level;
    } t_in;

    typedef struct packed {
        logic data_drive;
        logic clock_drive;
        logic drive_enable;
        logic busy_res;
        logic done_res;
        logic success;
    } t_out;

    typedef struct packed {
        logic [15:0] key_value;
        logic [15:0] clock_low_ticks;
        logic [15:0] clock_high_ticks;
        logic [15:0] pad_high_ticks;
        logic [15:0] pad_low_ticks;
        logic [15:0] ack_low_ticks;
        logic [19:0] ack_timeout_ticks;
        logic [7:0]  retry_limit;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/serial_key_handshake_with_ack_top.sv
// top level: input register, sequencer, result register and config port
`default_nettype none

// Each input transaction is one time-base tick and yields exactly one result
// transaction. A tick is taken into an input register, processed
// combinationally by the sequencer and written to a result register, so one
// tick per clock is sustained while the output side does not stall; the
// sequencer state updates only when a tick moves into the result register.
// The user must write configuration registers through the plain write port only
// while no run is in progress and no transaction is pending; the block does not enforce it.

module serial_key_handshake_with_ack_top import skh_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic r_in_valid, n_in_valid;
    t_in  r_in_data;
    logic r_out_valid, n_out_valid;
    t_out r_out_data;
    t_cfg cfg;
    t_out step_res;
    logic advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign n_in_valid  = (i_in_valid && !o_in_stall) || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && i_out_stall);

    skh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    skh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_success_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |-> !o_out_data.success)
        else $error("success without done");

    a_drive_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.drive_enable |-> o_out_data.busy_res)
        else $error("lines driven outside a run");

    a_released_lines_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.drive_enable
            |-> !o_out_data.data_drive && !o_out_data.clock_drive)
        else $error("drive values set while lines released");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> sv/skh_cfg.sv
// configuration register file
`default_nettype none

module skh_cfg import skh_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_VALUE:   n_cfg.key_value         = i_cfg_wdata[15:0];
                CFG_CLOCK_LOW:   n_cfg.clock_low_ticks   = i_cfg_wdata[15:0];
                CFG_CLOCK_HIGH:  n_cfg.clock_high_ticks  = i_cfg_wdata[15:0];
                CFG_PAD_HIGH:    n_cfg.pad_high_ticks    = i_cfg_wdata[15:0];
                CFG_PAD_LOW:     n_cfg.pad_low_ticks     = i_cfg_wdata[15:0];
                CFG_ACK_LOW:     n_cfg.ack_low_ticks     = i_cfg_wdata[15:0];
                CFG_ACK_TIMEOUT: n_cfg.ack_timeout_ticks = i_cfg_wdata[19:0];
                CFG_RETRY_LIMIT: n_cfg.retry_limit       = i_cfg_wdata[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_value         <= 16'd5871;
            r_cfg.clock_low_ticks   <= 16'd1;
            r_cfg.clock_high_ticks  <= 16'd1;
            r_cfg.pad_high_ticks    <= 16'd11;
            r_cfg.pad_low_ticks     <= 16'd7;
            r_cfg.ack_low_ticks     <= 16'd10;
            r_cfg.ack_timeout_ticks <= 20'd1000;
            r_cfg.retry_limit       <= 8'd10;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/skh_ctrl.sv
// handshake sequencer: phase state, timers and one tick of line control
`default_nettype none

module skh_ctrl import skh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire t_in  i_item,
    input  wire t_cfg i_cfg,
    output t_out      o_res
);

    t_phase               r_phase, n_phase;
    logic [BIT_POS_W-1:0] r_bit_pos, n_bit_pos;
    logic [15:0]          r_phase_timer, n_phase_timer;
    logic [15:0]          r_low_run, n_low_run;
    logic [19:0]          r_listen_timer, n_listen_timer;
    logic [7:0]           r_attempts, n_attempts;

    always_comb begin
        logic                 start;
        t_phase               ph;
        logic [BIT_POS_W-1:0] bp;
        logic [15:0]          pt;
        logic [15:0]          pt_inc;
        logic [15:0]          len;
        logic [15:0]          len_eff;
        logic                 phase_end;
        logic                 key_bit;
        logic [15:0]          lr;
        logic [15:0]          ack_eff;
        logic [19:0]          lt;
        logic [19:0]          tmo_eff;
        logic [7:0]           att;
        logic [7:0]           lim_eff;
        logic                 acked;

        start = (r_phase == PH_IDLE) && i_item.start_req;
        ph    = start ? PH_CLK_LOW : r_phase;
        bp    = start ? KEY_MSB_POS : r_bit_pos;
        pt    = start ? 16'd0 : r_phase_timer;
        att   = start ? 8'd0 : r_attempts;

        n_phase        = ph;
        n_bit_pos      = bp;
        n_phase_timer  = pt;
        n_low_run      = r_low_run;
        n_listen_timer = r_listen_timer;
        n_attempts     = att;
        o_res          = '0;

        // key register is 16 bits, higher positions shift out zero
        key_bit = bp[4] ? 1'b0 : i_cfg.key_value[bp[3:0]];

        unique case (ph)
            PH_CLK_LOW:  len = i_cfg.clock_low_ticks;
            PH_CLK_HIGH: len = i_cfg.clock_high_ticks;
            PH_PAD_HIGH: len = i_cfg.pad_high_ticks;
            PH_PAD_LOW:  len = i_cfg.pad_low_ticks;
            default:     len = 16'd1;
        endcase
        len_eff   = (len == 16'd0) ? 16'd1 : len;
        pt_inc    = pt + 16'd1;
        phase_end = (pt_inc >= len_eff) || (pt_inc == 16'd0);

        ack_eff = (i_cfg.ack_low_ticks == 16'd0) ? 16'd1 : i_cfg.ack_low_ticks;
        tmo_eff = (i_cfg.ack_timeout_ticks == 20'd0) ? 20'd1 : i_cfg.ack_timeout_ticks;
        lim_eff = (i_cfg.retry_limit == 8'd0) ? 8'd1 : i_cfg.retry_limit;

        lr    = 16'd0;
        lt    = 20'd0;
        acked = 1'b0;

        unique case (ph)
            PH_CLK_LOW, PH_CLK_HIGH, PH_PAD_HIGH, PH_PAD_LOW: begin
                o_res.data_drive   = key_bit;
                o_res.clock_drive  = (ph == PH_CLK_HIGH) || (ph == PH_PAD_HIGH);
                o_res.drive_enable = 1'b1;
                o_res.busy_res     = 1'b1;
                n_phase_timer      = phase_end ? 16'd0 : pt_inc;
                if (phase_end) begin
                    unique case (ph)
                        PH_CLK_LOW: n_phase = PH_CLK_HIGH;
                        PH_CLK_HIGH: begin
                            if (bp == '0) begin
                                n_phase = PH_PAD_HIGH;
                            end else begin
                                n_bit_pos = bp - 1'b1;
                                n_phase   = PH_CLK_LOW;
                            end
                        end
                        PH_PAD_HIGH: n_phase = PH_PAD_LOW;
                        default: begin
                            n_phase        = PH_LISTEN;
                            n_listen_timer = 20'd0;
                            n_low_run      = 16'd0;
                        end
                    endcase
                end
            end
            PH_LISTEN: begin
                o_res.busy_res = 1'b1;
                if (!i_item.data_line_level && !i_item.clock_line_level) begin
                    lr    = (r_low_run != 16'hFFFF) ? r_low_run + 16'd1 : r_low_run;
                    acked = (lr >= ack_eff);
                end
                n_low_run = lr;
                if (acked) begin
                    o_res.done_res = 1'b1;
                    o_res.success  = 1'b1;
                    n_phase        = PH_IDLE;
                end else begin
                    lt             = r_listen_timer + 20'd1;
                    n_listen_timer = lt;
                    if ((lt >= tmo_eff) || (lt == 20'd0)) begin
                        // attempt timed out
                        n_listen_timer = 20'd0;
                        n_low_run      = 16'd0;
                        n_attempts     = att + 8'd1;
                        if ((n_attempts >= lim_eff) || (n_attempts == 8'd0)) begin
                            o_res.done_res = 1'b1;
                            n_phase        = PH_IDLE;
                        end else begin
                            n_phase       = PH_CLK_LOW;
                            n_bit_pos     = KEY_MSB_POS;
                            n_phase_timer = 16'd0;
                        end
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_pos      <= '0;
            r_phase_timer  <= '0;
            r_low_run      <= '0;
            r_listen_timer <= '0;
            r_attempts     <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_bit_pos      <= n_bit_pos;
            r_phase_timer  <= n_phase_timer;
            r_low_run      <= n_low_run;
            r_listen_timer <= n_listen_timer;
            r_attempts     <= n_attempts;
        end
    end

endmodule

`default_nettype wire

>>> sim/serial_key_handshake_with_ack_top_test.sv
// self-checking testbench for the serial key handshake block with acknowledge
`default_nettype none

module serial_key_handshake_with_ack_top_test;
    import skh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_SETS    = 8;
    localparam int TICKS_PER_SET  = 100;
    localparam int DIR_ROWS       = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    serial_key_handshake_with_ack_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sequencer mirror
    t_cfg         seq_cfg;
    t_phase       seq_phase;
    logic [4:0]   seq_bit;
    logic [15:0]  seq_timer;
    logic [15:0]  seq_low_run;
    logic [19:0]  seq_listen;
    logic [7:0]   seq_tries;

    t_out expected_drives[$];
    int   mismatches = 0;
    int   snd_pct = 7;
    int   rcv_pct = 50;
    int   quiet_cycles = 0;
    bit   ack_wanted = 1'b0;
    t_out got;

    typedef struct {
        t_in  stim;
        bit   typed;
        t_out want;
    } t_dir_row;

    // reset config: key msb first is 0,0,0,1,...
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{3'b011, 1'b1, 6'b000000},  // idle, lines released
        '{3'b000, 1'b1, 6'b000000},  // idle, low levels ignored
        '{3'b110, 1'b1, 6'b001100},  // start tick is first clock-low of msb
        '{3'b101, 1'b1, 6'b011100},  // start while busy is ignored
        '{3'b000, 1'b1, 6'b001100},  // levels ignored outside listen
        '{3'b000, 1'b0, 6'b000000},
        '{3'b111, 1'b0, 6'b000000},
        '{3'b010, 1'b0, 6'b000000},
        '{3'b001, 1'b0, 6'b000000},
        '{3'b100, 1'b0, 6'b000000},
        '{3'b011, 1'b0, 6'b000000},
        '{3'b000, 1'b0, 6'b000000},
        '{3'b110, 1'b0, 6'b000000},
        '{3'b101, 1'b0, 6'b000000},
        '{3'b000, 1'b0, 6'b000000},
        '{3'b011, 1'b0, 6'b000000},
        '{3'b100, 1'b0, 6'b000000},
        '{3'b001, 1'b0, 6'b000000},
        '{3'b010, 1'b0, 6'b000000},
        '{3'b111, 1'b0, 6'b000000}
    };

    function automatic logic [19:0] min_one(input logic [19:0] v);
        return (v == '0) ? 20'd1 : v;
    endfunction

    function automatic bit phase_done(input logic [15:0] len);
        seq_timer = seq_timer + 16'd1;
        if (seq_timer >= min_one(len) || seq_timer == '0) begin
            seq_timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void restart_key();
        seq_phase = PH_CLK_LOW;
        seq_bit   = KEY_MSB_POS;
        seq_timer = '0;
    endfunction

    task automatic sequencer_step(input t_in x, output t_out r);
        bit acked;
        r = '0;
        acked = 1'b0;
        if (seq_phase == PH_IDLE && x.start_req) begin
            seq_tries = '0;
            restart_key();
        end
        case (seq_phase)
            PH_CLK_LOW: begin
                r = '{data_drive: seq_cfg.key_value[seq_bit[3:0]], clock_drive: 1'b0,
                      drive_enable: 1'b1, busy_res: 1'b1, default: 1'b0};
                if (phase_done(seq_cfg.clock_low_ticks))
                    seq_phase = PH_CLK_HIGH;
            end
            PH_CLK_HIGH: begin
                r = '{data_drive: seq_cfg.key_value[seq_bit[3:0]], clock_drive: 1'b1,
                      drive_enable: 1'b1, busy_res: 1'b1, default: 1'b0};
                if (phase_done(seq_cfg.clock_high_ticks)) begin
                    if (seq_bit == '0) begin
                        seq_phase = PH_PAD_HIGH;
                    end else begin
                        seq_bit   = seq_bit - 5'd1;
                        seq_phase = PH_CLK_LOW;
                    end
                end
            end
            PH_PAD_HIGH: begin
                r = '{data_drive: seq_cfg.key_value[seq_bit[3:0]], clock_drive: 1'b1,
                      drive_enable: 1'b1, busy_res: 1'b1, default: 1'b0};
                if (phase_done(seq_cfg.pad_high_ticks))
                    seq_phase = PH_PAD_LOW;
            end
            PH_PAD_LOW: begin
                r = '{data_drive: seq_cfg.key_value[seq_bit[3:0]], clock_drive: 1'b0,
                      drive_enable: 1'b1, busy_res: 1'b1, default: 1'b0};
                if (phase_done(seq_cfg.pad_low_ticks)) begin
                    seq_phase   = PH_LISTEN;
                    seq_listen  = '0;
                    seq_low_run = '0;
                end
            end
            PH_LISTEN: begin
                r.busy_res = 1'b1;
                if (!x.data_line_level && !x.clock_line_level) begin
                    if (seq_low_run != 16'hFFFF)
                        seq_low_run = seq_low_run + 16'd1;
                    acked = (seq_low_run >= min_one(seq_cfg.ack_low_ticks));
                end else begin
                    seq_low_run = '0;
                end
                if (acked) begin
                    r.done_res = 1'b1;
                    r.success  = 1'b1;
                    seq_phase  = PH_IDLE;
                end else begin
                    seq_listen = seq_listen + 20'd1;
                    if (seq_listen >= min_one(seq_cfg.ack_timeout_ticks) || seq_listen == '0) begin
                        seq_listen  = '0;
                        seq_low_run = '0;
                        seq_tries   = seq_tries + 8'd1;
                        // out of attempts ends the run in failure
                        if (seq_tries >= min_one(seq_cfg.retry_limit) || seq_tries == '0) begin
                            r.done_res = 1'b1;
                            seq_phase  = PH_IDLE;
                        end else begin
                            restart_key();
                        end
                    end
                end
            end
            default: seq_phase = PH_IDLE;
        endcase
    endtask

    task automatic send_tick(input t_in x, input bit typed, input t_out typed_val);
        t_out r;
        while ($urandom_range(99) < snd_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sequencer_step(x, r);
        expected_drives.push_back(typed ? typed_val : r);
    endtask

    // hold off the sender until every expected result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg c);
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] v;
        for (int k = 0; k < 8; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_KEY_VALUE:   v = CFG_DATA_W'(c.key_value);
                CFG_CLOCK_LOW:   v = CFG_DATA_W'(c.clock_low_ticks);
                CFG_CLOCK_HIGH:  v = CFG_DATA_W'(c.clock_high_ticks);
                CFG_PAD_HIGH:    v = CFG_DATA_W'(c.pad_high_ticks);
                CFG_PAD_LOW:     v = CFG_DATA_W'(c.pad_low_ticks);
                CFG_ACK_LOW:     v = CFG_DATA_W'(c.ack_low_ticks);
                CFG_ACK_TIMEOUT: v = c.ack_timeout_ticks;
                default:         v = CFG_DATA_W'(c.retry_limit);
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx;
            i_cfg_wdata <= v;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        seq_cfg = c;
    endtask

    task automatic pick_tick(output t_in x);
        x.start_req = (seq_phase == PH_IDLE) ? ($urandom_range(3) == 0)
                                             : ($urandom_range(7) == 0);
        if ($urandom_range(19) == 0)
            ack_wanted = !ack_wanted;
        if (seq_phase == PH_LISTEN && ack_wanted && $urandom_range(9) != 0)
            {x.data_line_level, x.clock_line_level} = 2'b00;
        else
            {x.data_line_level, x.clock_line_level} = 2'($urandom_range(3));
    endtask

    // one setting: write it, start a run at once, random ticks, then finish the run
    task automatic run_setting(input t_cfg c, input int n_ticks);
        t_in x;
        settle();
        load_settings(c);
        for (int i = 0; i < n_ticks; i++) begin
            pick_tick(x);
            if (i == 0)
                x.start_req = 1'b1;
            if ($urandom_range(149) == 0)
                settle();
            send_tick(x, 1'b0, '0);
        end
        while (seq_phase != PH_IDLE)
            send_tick(3'b000, 1'b0, '0);
    endtask

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.key_value         = 16'($urandom_range(16'hFFFF));
        c.clock_low_ticks   = 16'($urandom_range(2));
        c.clock_high_ticks  = 16'($urandom_range(2));
        c.pad_high_ticks    = 16'($urandom_range(4));
        c.pad_low_ticks     = 16'($urandom_range(4));
        c.ack_low_ticks     = 16'($urandom_range(1, 4));
        c.ack_timeout_ticks = 20'($urandom_range(1, 24));
        c.retry_limit       = 8'($urandom_range(1, 4));
        return c;
    endfunction

    task automatic check_field(input string name, input logic want, input logic act);
        if (want !== act) begin
            $display("%0t: %s expected %b got %b", $time, name, want, act);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_drives.size() == 0) begin
                $display("%0t: result with no transaction pending, expected none got %b",
                         $time, o_out_data);
                mismatches++;
            end else begin
                got = expected_drives.pop_front();
                check_field("data_drive", got.data_drive, o_out_data.data_drive);
                check_field("clock_drive", got.clock_drive, o_out_data.clock_drive);
                check_field("drive_enable", got.drive_enable, o_out_data.drive_enable);
                check_field("busy_res", got.busy_res, o_out_data.busy_res);
                check_field("done_res", got.done_res, o_out_data.done_res);
                check_field("success", got.success, o_out_data.success);
            end
        end
        i_out_stall <= ($urandom_range(99) < rcv_pct);
    end

    // ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cfg c;
        seq_cfg = '{key_value: 16'd5871, clock_low_ticks: 16'd1, clock_high_ticks: 16'd1,
                    pad_high_ticks: 16'd11, pad_low_ticks: 16'd7, ack_low_ticks: 16'd10,
                    ack_timeout_ticks: 20'd1000, retry_limit: 8'd10};
        seq_phase   = PH_IDLE;
        seq_bit     = '0;
        seq_timer   = '0;
        seq_low_run = '0;
        seq_listen  = '0;
        seq_tries   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_pct = 7;
        rcv_pct = 50;
        for (int i = 0; i < DIR_ROWS; i++)
            send_tick(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        // finish the reset-config run with an acknowledge
        while (seq_phase != PH_IDLE)
            send_tick(3'b000, 1'b0, '0);

        // every count zero, taken as one
        run_setting('0, 40);
        // all-ones key, acknowledge unreachable, every attempt times out
        c = '{key_value: 16'hFFFF, ack_low_ticks: 16'hFFFF, ack_timeout_ticks: 20'd3,
              retry_limit: 8'd4, default: '0};
        run_setting(c, 10);

        for (int s = 0; s < RANDOM_SETS; s++) begin
            if (s == 3) begin
                snd_pct = 50;
                rcv_pct = 7;
                c = rand_cfg();
                c.ack_low_ticks     = 16'd1;
                c.ack_timeout_ticks = 20'hFFFFF;
                c.retry_limit       = 8'd1;
                run_setting(c, 60);
            end else if (s == 6) begin
                snd_pct = 0;
                rcv_pct = 0;
            end
            run_setting(rand_cfg(), TICKS_PER_SET);
        end

        // longer phases and acknowledge run, one attempt
        c = '{key_value: 16'($urandom_range(16'hFFFF)), clock_low_ticks: 16'd3,
              clock_high_ticks: 16'd2, pad_high_ticks: 16'd40, pad_low_ticks: 16'd30,
              ack_low_ticks: 16'd20, ack_timeout_ticks: 20'hFFFFF, retry_limit: 8'd1};
        run_setting(c, 5);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
